// ===== rtl/tch_pkg.sv =====
// shared types, constants and helper functions for the tilt-compensated heading block
package tch_pkg;

   localparam int ANG_W = 34;   // signed q2.30 angle
   localparam int SC_W  = 33;   // signed q2.30 sine / cosine
   localparam int Q13_W = 17;   // signed q3.13 angle after rounding
   localparam int HEADING_W = 16;
   localparam int TILT_W = 15;

   typedef logic signed [ANG_W-1:0] angle_type;
   typedef logic signed [SC_W-1:0] sc_type;
   typedef logic signed [Q13_W-1:0] q13_type;

   localparam angle_type ANG_HALF_PI  = 34'sd1686629713;
   localparam angle_type ANG_PI       = 34'sd3373259426;
   localparam angle_type ANG_ROUND    = 34'sd65536;
   localparam sc_type    ROT_GAIN_INV = 33'sd652032874;
   localparam q13_type   HEADING_MAX  = 17'sd25736;
   localparam logic [TILT_W-1:0] TILT_RESET = 15'd6390;

   // atan(2^-i) in q2.30
   function automatic angle_type atan_step(input int i);
      angle_type r;
      case (i)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021687;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         10: r = 34'sd1048576;
         default: r = (i > 30) ? '0 : (angle_type'(1) <<< (30 - i));
      endcase
      return r;
   endfunction

   // q2.30 to q3.13, round half up
   function automatic q13_type to_q13(input angle_type a);
      angle_type r;
      r = a + ANG_ROUND;
      return r[ANG_W-1:17];
   endfunction

endpackage

// ===== rtl/tch_if.sv =====
// request and response channel interfaces
interface tch_req_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic valid;
   logic ready;
   logic signed [SAMPLE_WIDTH-1:0] mag_x;
   logic signed [SAMPLE_WIDTH-1:0] mag_y;
   logic signed [SAMPLE_WIDTH-1:0] mag_z;
   logic signed [SAMPLE_WIDTH-1:0] acc_x;
   logic signed [SAMPLE_WIDTH-1:0] acc_y;
   logic signed [SAMPLE_WIDTH-1:0] acc_z;

   modport source (output valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, input ready);
   modport sink (input valid, mag_x, mag_y, mag_z, acc_x, acc_y, acc_z, output ready);
endinterface

interface tch_rsp_if ();
   logic valid;
   logic ready;
   logic signed [15:0] heading;
   logic tilt_exceeded;

   modport source (output valid, heading, tilt_exceeded, input ready);
   modport sink (input valid, heading, tilt_exceeded, output ready);
endinterface

// ===== rtl/tilt_compensated_heading_top.sv =====
// top level of the tilt-compensated compass heading pipeline
// Usage
//   req_ch carries one word per cycle: a magnetometer and an accelerometer
//   sample, each axis signed q2.(SAMPLE_WIDTH-2). rsp_ch returns one word per
//   request, in order: heading in q3.13 radians, saturated to +-25736, and
//   tilt_exceeded, set (with heading 0) when |roll| or |pitch| in q3.13 is
//   above tilt_limit. csr_we/csr_wdata write tilt_limit; write it only while
//   no words are in flight.
// Pipeline and throughput
//   From request to response a word passes through the square-root pipeline
//   (SAMPLE_WIDTH + 9 stages), the roll/pitch vectoring cordics, the
//   sine/cosine cordics (CORDIC_STEPS + 1 each), four projection stages,
//   the heading cordic and the output register.
//   One word per cycle is taken while the response side keeps up.
// Reset and stall
//   reset empties the pipeline and loads tilt_limit with 6390 (0.78 rad).
//   While a response waits in the output register and rsp_ch.ready is low,
//   the whole pipeline holds and req_ch.ready is low; nothing is dropped.
module tilt_compensated_heading_top #(
   parameter int CORDIC_STEPS = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   tch_req_if.sink                    req_ch,
   tch_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [tch_pkg::TILT_W-1:0] csr_wdata
);
   localparam int SW   = SAMPLE_WIDTH;
   localparam int RB   = SW + 8;
   localparam int VIW  = SW + 25;
   localparam int HIW  = SW + tch_pkg::SC_W + 3;
   localparam int Q13W = tch_pkg::Q13_W;

   logic en;
   logic [tch_pkg::TILT_W-1:0] tilt_limit_ff;
   logic rsp_valid_ff, flag_ff;
   logic signed [tch_pkg::HEADING_W-1:0] heading_ff, heading_in;

   // square root stage
   logic sq_valid;
   logic [RB-1:0] sq_root;
   logic [6*SW-1:0] sq_side;
   logic signed [SW-1:0] s_mx, s_my, s_mz, s_ax, s_ay, s_az;

   // roll and pitch
   logic ang_valid;
   tch_pkg::angle_type roll, pitch_raw, pitch;
   logic [3*SW-1:0] ang_side;
   tch_pkg::q13_type r13, p13;
   logic [Q13W-1:0] r_abs, p_abs;
   logic over;

   // sine and cosine
   logic sc_valid;
   tch_pkg::sc_type sr, cr, sp, cp;
   logic [3*SW:0] sc_side;

   // projection and heading
   logic pj_valid;
   logic signed [HIW-1:0] xh, yh;
   logic pj_over, hd_valid, hd_over;
   tch_pkg::angle_type hd_angle;
   tch_pkg::q13_type hd13;

   assign en = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_limit_ff <= tch_pkg::TILT_RESET;
      end else if (csr_we) begin
         tilt_limit_ff <= csr_wdata;
      end
   end

   tch_isqrt #(.SW(SW), .SIDE_W(6*SW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .in_a     (req_ch.acc_y),
      .in_b     (req_ch.acc_z),
      .in_side  ({req_ch.mag_x, req_ch.mag_y, req_ch.mag_z,
                  req_ch.acc_x, req_ch.acc_y, req_ch.acc_z}),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   assign {s_mx, s_my, s_mz, s_ax, s_ay, s_az} = sq_side;

   tch_vec_cordic #(.STEPS(CORDIC_STEPS), .IN_W(VIW), .SIDE_W(3*SW)) u_roll (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .in_x     ({s_az[SW-1], s_az, 24'b0}),
      .in_y     ({s_ay[SW-1], s_ay, 24'b0}),
      .in_side  ({s_mx, s_my, s_mz}),
      .out_valid(ang_valid),
      .out_angle(roll),
      .out_side (ang_side)
   );

   tch_vec_cordic #(.STEPS(CORDIC_STEPS), .IN_W(VIW), .SIDE_W(1)) u_pitch (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .in_x     ({1'b0, sq_root, 16'b0}),
      .in_y     ({s_ax[SW-1], s_ax, 24'b0}),
      .in_side  (1'b0),
      .out_valid(),
      .out_angle(pitch_raw),
      .out_side ()
   );

   assign pitch = -pitch_raw;

   // tilt check on the rounded angles
   assign r13 = tch_pkg::to_q13(roll);
   assign p13 = tch_pkg::to_q13(pitch);
   assign r_abs = r13[Q13W-1] ? Q13W'(-r13) : Q13W'(r13);
   assign p_abs = p13[Q13W-1] ? Q13W'(-p13) : Q13W'(p13);
   assign over = (r_abs > Q13W'(tilt_limit_ff)) || (p_abs > Q13W'(tilt_limit_ff));

   tch_rot_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(3*SW+1)) u_sc_roll (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ang_valid),
      .in_angle (roll),
      .in_side  ({ang_side, over}),
      .out_valid(sc_valid),
      .out_sin  (sr),
      .out_cos  (cr),
      .out_side (sc_side)
   );

   tch_rot_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(1)) u_sc_pitch (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ang_valid),
      .in_angle (pitch),
      .in_side  (1'b0),
      .out_valid(),
      .out_sin  (sp),
      .out_cos  (cp),
      .out_side ()
   );

   tch_proj #(.SW(SW), .SIDE_W(1)) u_proj (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sc_valid),
      .in_mx    (sc_side[3*SW:2*SW+1]),
      .in_my    (sc_side[2*SW:SW+1]),
      .in_mz    (sc_side[SW:1]),
      .in_sr    (sr),
      .in_cr    (cr),
      .in_sp    (sp),
      .in_cp    (cp),
      .in_side  (sc_side[0]),
      .out_valid(pj_valid),
      .out_xh   (xh),
      .out_yh   (yh),
      .out_side (pj_over)
   );

   tch_vec_cordic #(.STEPS(CORDIC_STEPS), .IN_W(HIW), .SIDE_W(1)) u_heading (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (pj_valid),
      .in_x     (xh),
      .in_y     (yh),
      .in_side  (pj_over),
      .out_valid(hd_valid),
      .out_angle(hd_angle),
      .out_side (hd_over)
   );

   assign hd13 = tch_pkg::to_q13(hd_angle);

   always_comb begin
      if (hd_over) begin
         heading_in = '0;
      end else if (hd13 > tch_pkg::HEADING_MAX) begin
         heading_in = tch_pkg::HEADING_W'(tch_pkg::HEADING_MAX);
      end else if (hd13 < -tch_pkg::HEADING_MAX) begin
         heading_in = tch_pkg::HEADING_W'(-tch_pkg::HEADING_MAX);
      end else begin
         heading_in = tch_pkg::HEADING_W'(hd13);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= hd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff <= heading_in;
         flag_ff <= hd_over;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.heading = heading_ff;
   assign rsp_ch.tilt_exceeded = flag_ff;
endmodule

// ===== rtl/tch_isqrt.sv =====
// pipelined integer square root of (a^2 + b^2) * 2^16, one result bit per stage
module tch_isqrt #(
   parameter int SW     = 16,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [SW-1:0] in_a,
   input  logic signed [SW-1:0] in_b,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [SW+7:0]       out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int VW = 2*SW + 16;
   localparam int RB = SW + 8;

   logic signed [2*SW-1:0] sq_a, sq_b;
   logic [2*SW-1:0] sum_in;
   logic [RB:0] valid_ff;
   logic [VW-1:0] v_ff [0:RB];
   logic [RB+1:0] rem_ff [0:RB];
   logic [RB-1:0] root_ff [0:RB];
   logic [SIDE_W-1:0] side_ff [0:RB];
   logic [VW-1:0] v_in [1:RB];
   logic [RB+1:0] rem_in [1:RB];
   logic [RB-1:0] root_in [1:RB];

   assign sq_a = in_a * in_a;
   assign sq_b = in_b * in_b;
   assign sum_in = sq_a + sq_b;

   always_comb begin
      logic [RB+1:0] remx, trial;
      for (int k = 0; k < RB; k++) begin
         remx = {rem_ff[k][RB-1:0], v_ff[k][VW-1:VW-2]};
         trial = {root_ff[k], 2'b01};
         v_in[k+1] = {v_ff[k][VW-3:0], 2'b00};
         if (remx >= trial) begin
            rem_in[k+1] = remx - trial;
            root_in[k+1] = {root_ff[k][RB-2:0], 1'b1};
         end else begin
            rem_in[k+1] = remx;
            root_in[k+1] = {root_ff[k][RB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[RB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0] <= {sum_in, 16'b0};
         rem_ff[0] <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
         for (int k = 1; k <= RB; k++) begin
            v_ff[k] <= v_in[k];
            rem_ff[k] <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[RB];
   assign out_root = root_ff[RB];
   assign out_side = side_ff[RB];
endmodule

// ===== rtl/tch_vec_cordic.sv =====
// pipelined vectoring cordic: atan2(y, x) in q2.30, one iteration per stage
module tch_vec_cordic #(
   parameter int STEPS  = 16,
   parameter int IN_W   = 41,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [IN_W-1:0] in_x,
   input  logic signed [IN_W-1:0] in_y,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output tch_pkg::angle_type    out_angle,
   output logic [SIDE_W-1:0]     out_side
);
   localparam int W = IN_W + 3;

   logic signed [W-1:0] xe, ye, x0_in, y0_in;
   tch_pkg::angle_type z0_in;
   logic [STEPS:0] valid_ff, zero_ff;
   logic signed [W-1:0] x_ff [0:STEPS];
   logic signed [W-1:0] y_ff [0:STEPS];
   tch_pkg::angle_type z_ff [0:STEPS];
   logic [SIDE_W-1:0] side_ff [0:STEPS];
   logic signed [W-1:0] x_in [1:STEPS];
   logic signed [W-1:0] y_in [1:STEPS];
   tch_pkg::angle_type z_in [1:STEPS];

   assign xe = W'(in_x);
   assign ye = W'(in_y);

   // left half-plane: quarter turn first
   always_comb begin
      x0_in = xe;
      y0_in = ye;
      z0_in = '0;
      if (xe < 0) begin
         if (ye >= 0) begin
            x0_in = ye;
            y0_in = -xe;
            z0_in = tch_pkg::ANG_HALF_PI;
         end else begin
            x0_in = -ye;
            y0_in = xe;
            z0_in = -tch_pkg::ANG_HALF_PI;
         end
      end
   end

   always_comb begin
      logic signed [W-1:0] dx, dy;
      for (int i = 0; i < STEPS; i++) begin
         dx = x_ff[i] >>> i;
         dy = y_ff[i] >>> i;
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + dy;
            y_in[i+1] = y_ff[i] - dx;
            z_in[i+1] = z_ff[i] + tch_pkg::atan_step(i);
         end else begin
            x_in[i+1] = x_ff[i] - dy;
            y_in[i+1] = y_ff[i] + dx;
            z_in[i+1] = z_ff[i] - tch_pkg::atan_step(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
         zero_ff <= {zero_ff[STEPS-1:0], (xe == 0) && (ye == 0)};
         side_ff[0] <= in_side;
         for (int i = 1; i <= STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_angle = zero_ff[STEPS] ? '0 : z_ff[STEPS];
   assign out_side = side_ff[STEPS];
endmodule

// ===== rtl/tch_rot_cordic.sv =====
// pipelined rotation cordic: sine and cosine of a q2.30 angle
module tch_rot_cordic #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tch_pkg::angle_type in_angle,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output tch_pkg::sc_type    out_sin,
   output tch_pkg::sc_type    out_cos,
   output logic [SIDE_W-1:0]  out_side
);
   tch_pkg::angle_type a0_in;
   logic neg_in;
   logic [STEPS:0] valid_ff, neg_ff;
   tch_pkg::sc_type x_ff [0:STEPS];
   tch_pkg::sc_type y_ff [0:STEPS];
   tch_pkg::angle_type a_ff [0:STEPS];
   logic [SIDE_W-1:0] side_ff [0:STEPS];
   tch_pkg::sc_type x_in [1:STEPS];
   tch_pkg::sc_type y_in [1:STEPS];
   tch_pkg::angle_type a_in [1:STEPS];

   // fold into the right half-plane, negate results at the end
   always_comb begin
      a0_in = in_angle;
      neg_in = 1'b0;
      if (in_angle > tch_pkg::ANG_HALF_PI) begin
         a0_in = in_angle - tch_pkg::ANG_PI;
         neg_in = 1'b1;
      end else if (in_angle < -tch_pkg::ANG_HALF_PI) begin
         a0_in = in_angle + tch_pkg::ANG_PI;
         neg_in = 1'b1;
      end
   end

   always_comb begin
      tch_pkg::sc_type dx, dy;
      for (int i = 0; i < STEPS; i++) begin
         dx = x_ff[i] >>> i;
         dy = y_ff[i] >>> i;
         if (a_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - dy;
            y_in[i+1] = y_ff[i] + dx;
            a_in[i+1] = a_ff[i] - tch_pkg::atan_step(i);
         end else begin
            x_in[i+1] = x_ff[i] + dy;
            y_in[i+1] = y_ff[i] - dx;
            a_in[i+1] = a_ff[i] + tch_pkg::atan_step(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= tch_pkg::ROT_GAIN_INV;
         y_ff[0] <= '0;
         a_ff[0] <= a0_in;
         neg_ff <= {neg_ff[STEPS-1:0], neg_in};
         side_ff[0] <= in_side;
         for (int i = 1; i <= STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            a_ff[i] <= a_in[i];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_sin = neg_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
   assign out_cos = neg_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
   assign out_side = side_ff[STEPS];
endmodule

// ===== rtl/tch_proj.sv =====
// four-stage projection of the field onto the level plane
module tch_proj #(
   parameter int SW     = 16,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [SW-1:0] in_mx,
   input  logic signed [SW-1:0] in_my,
   input  logic signed [SW-1:0] in_mz,
   input  tch_pkg::sc_type     in_sr,
   input  tch_pkg::sc_type     in_cr,
   input  tch_pkg::sc_type     in_sp,
   input  tch_pkg::sc_type     in_cp,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic signed [SW+tch_pkg::SC_W+2:0] out_xh,
   output logic signed [SW+tch_pkg::SC_W+2:0] out_yh,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int SCW = tch_pkg::SC_W;
   localparam int PW  = SW + SCW;
   localparam int TW  = SCW + 2;
   localparam int OW  = SW + SCW + 3;

   logic [3:0] valid_ff;
   logic [SIDE_W-1:0] side_ff [0:3];
   // stage 1
   logic signed [PW-1:0] xc_ff, zs_ff, yc1_ff;
   logic signed [2*SCW-1:0] ss_ff, sc_ff;
   logic signed [SW-1:0] mx1_ff, mz1_ff;
   logic signed [PW-1:0] xc_in, zs_in, yc_in;
   logic signed [2*SCW-1:0] ss_in, sc_in;
   // stage 2
   logic signed [OW-1:0] xh2_ff, xh2_in;
   logic signed [TW-1:0] t1_ff, t2_ff;
   logic signed [PW-1:0] yc2_ff;
   logic signed [SW-1:0] mx2_ff, mz2_ff;
   // stage 3
   logic signed [SW+TW-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic signed [OW-1:0] xh3_ff;
   logic signed [PW-1:0] yc3_ff;
   // stage 4
   logic signed [OW-1:0] xh4_ff, yh4_ff, yh_in;

   assign xc_in = in_mx * in_cp;
   assign zs_in = in_mz * in_sp;
   assign yc_in = in_my * in_cr;
   assign ss_in = in_sr * in_sp;
   assign sc_in = in_sr * in_cp;
   assign xh2_in = OW'(xc_ff) + OW'(zs_ff);
   assign p1_in = mx2_ff * t1_ff;
   assign p2_in = mz2_ff * t2_ff;
   assign yh_in = OW'(p1_ff) + OW'(yc3_ff) - OW'(p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xc_ff <= xc_in;
         zs_ff <= zs_in;
         yc1_ff <= yc_in;
         ss_ff <= ss_in;
         sc_ff <= sc_in;
         mx1_ff <= in_mx;
         mz1_ff <= in_mz;

         xh2_ff <= xh2_in;
         t1_ff <= TW'(ss_ff >>> 30);
         t2_ff <= TW'(sc_ff >>> 30);
         yc2_ff <= yc1_ff;
         mx2_ff <= mx1_ff;
         mz2_ff <= mz1_ff;

         p1_ff <= p1_in;
         p2_ff <= p2_in;
         xh3_ff <= xh2_ff;
         yc3_ff <= yc2_ff;

         xh4_ff <= xh3_ff;
         yh4_ff <= yh_in;

         side_ff[0] <= in_side;
         for (int i = 1; i < 4; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[3];
   assign out_xh = xh4_ff;
   assign out_yh = yh4_ff;
   assign out_side = side_ff[3];
endmodule
